/* hw/rtl/tpct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpct_pkg
// Shared types and constants for the two-finger touch contact tracker.
// ----------------------------------------------------------------------------
package tpct_pkg;

  localparam int unsigned CoordW     = 12;
  localparam int unsigned ScaleShift = 23;
  localparam int unsigned KW         = ScaleShift;   // all ratios are below one
  localparam int unsigned ProdW      = CoordW + KW;

  localparam logic [7:0] CoordPacket = 8'h5A;

  // Register indexes on the configuration port
  localparam logic CfgDisplayMode  = 1'b0;
  localparam logic CfgFlipVertical = 1'b1;

  // Event kinds carried in tuser
  localparam logic KindContact   = 1'b0;
  localparam logic KindFrameSync = 1'b1;

  // floor(v*A/B) == (v*ceil(A*2^23/B)) >> 23 for every 12-bit v and the B used here
  localparam logic [63:0] KX0Full = ((64'd799 << ScaleShift) + 64'd1087) / 64'd1088;
  localparam logic [63:0] KY0Full = ((64'd599 << ScaleShift) + 64'd767) / 64'd768;
  localparam logic [63:0] KX1Full = ((64'd1023 << ScaleShift) + 64'd1279) / 64'd1280;
  localparam logic [63:0] KY1Full = ((64'd757 << ScaleShift) + 64'd831) / 64'd832;

  localparam logic [KW-1:0] KX0 = KX0Full[KW-1:0];
  localparam logic [KW-1:0] KY0 = KY0Full[KW-1:0];
  localparam logic [KW-1:0] KX1 = KX1Full[KW-1:0];
  localparam logic [KW-1:0] KY1 = KY1Full[KW-1:0];

  localparam logic [CoordW-1:0] Mode0XMax = 12'd799;
  localparam logic [CoordW-1:0] Mode1YMax = 12'd757;

  typedef struct packed {
    logic display_mode;
    logic flip_vertical;
  } cfg_t;

  typedef struct packed {
    logic              event_kind;
    logic              contact_slot;
    logic              touching;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic              last_of_run;
  } res_t;

endpackage

/* hw/rtl/tpct_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpct_scaler
// Maps one raw 12-bit touch point to screen pixels for the selected mode.
// ----------------------------------------------------------------------------
module tpct_scaler (
  input  tpct_pkg::cfg_t                  cfg_i,
  input  logic [7:0]                      high_nibbles_i,
  input  logic [7:0]                      x_low_i,
  input  logic [7:0]                      y_low_i,
  output logic [tpct_pkg::CoordW-1:0]     pos_x_o,
  output logic [tpct_pkg::CoordW-1:0]     pos_y_o,
  output logic                            nonzero_o
);
  import tpct_pkg::*;

  logic [CoordW-1:0] raw_x, raw_y, op_x, op_y, quo_x, quo_y;
  logic [KW-1:0]     k_x, k_y;
  logic [ProdW-1:0]  prod_x, prod_y;

  assign raw_x = {high_nibbles_i[7:4], x_low_i};
  assign raw_y = {high_nibbles_i[3:0], y_low_i};

  // mode 1 swaps the axes
  assign op_x = cfg_i.display_mode ? raw_y : raw_x;
  assign op_y = cfg_i.display_mode ? raw_x : raw_y;
  assign k_x  = cfg_i.display_mode ? KX1 : KX0;
  assign k_y  = cfg_i.display_mode ? KY1 : KY0;

  assign prod_x = ProdW'(op_x) * ProdW'(k_x);
  assign prod_y = ProdW'(op_y) * ProdW'(k_y);
  assign quo_x  = prod_x[ProdW-1:ScaleShift];
  assign quo_y  = prod_y[ProdW-1:ScaleShift];

  always_comb begin
    if (cfg_i.display_mode) begin
      pos_x_o = quo_x;
      if (cfg_i.flip_vertical) begin
        pos_y_o = (quo_y > Mode1YMax) ? '0 : Mode1YMax - quo_y;
      end else begin
        pos_y_o = quo_y;
      end
    end else begin
      pos_x_o = (quo_x > Mode0XMax) ? '0 : Mode0XMax - quo_x;
      pos_y_o = quo_y;
    end
  end

  assign nonzero_o = (raw_x != '0) || (raw_y != '0);

endmodule

/* hw/rtl/touch_packet_contact_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_packet_contact_tracker_unit
// Two-finger contact tracker: scales coordinate packets and emits contact
// reports followed by a frame sync.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_axis    | in  | one 8-byte controller packet
//  m_axis    | out | one contact report or frame sync (tlast on frame sync)
//  cfg       | in  | register write, index 0 display_mode, 1 flip_vertical
//
//  A packet waits in the input register, is scaled there and its results
//  (none for a non-coordinate packet, else one to three) drop into a
//  three-entry result buffer that drains one beat per cycle while m_axis
//  is ready. The next packet is taken while results are still draining.
//  Reset clears the valid flags, contact mask, last positions and config.
//  A stalled m_axis holds its beat; s_axis stalls once the input register
//  is full and the result buffer does not empty in that cycle.
// ----------------------------------------------------------------------------
module touch_packet_contact_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // packet_type, first_high_nibbles, first_x_low, first_y_low,
  // second_high_nibbles, second_x_low, second_y_low, status_byte
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // contact_slot, touching, pos_x[11:0], pos_y[11:0], 6 zero bits
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // event_kind
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);
  import tpct_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [63:0]       pkt_q;
  logic [1:0]        pressed_q, pressed_d;
  logic [CoordW-1:0] last0_x_q, last0_y_q, last1_x_q, last1_y_q;
  res_t              ent_q [3];
  logic [1:0]        cnt_q;

  logic              load_w, out_fire, in_fire;
  logic              coord, all_lift, rep0, rep1;
  logic [CoordW-1:0] s0_x, s0_y, s1_x, s1_y;
  logic              nz0, nz1;
  res_t              r0, r1, sync_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDisplayMode:  cfg_q.display_mode  <= cfg_wdata_i;
        CfgFlipVertical: cfg_q.flip_vertical <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign load_w        = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign s_axis_tready = !in_valid_q || load_w;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (load_w) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pkt_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------- scaling
  tpct_scaler u_scale0 (
    .cfg_i          (cfg_q),
    .high_nibbles_i (pkt_q[15:8]),
    .x_low_i        (pkt_q[23:16]),
    .y_low_i        (pkt_q[31:24]),
    .pos_x_o        (s0_x),
    .pos_y_o        (s0_y),
    .nonzero_o      (nz0)
  );

  tpct_scaler u_scale1 (
    .cfg_i          (cfg_q),
    .high_nibbles_i (pkt_q[39:32]),
    .x_low_i        (pkt_q[47:40]),
    .y_low_i        (pkt_q[55:48]),
    .pos_x_o        (s1_x),
    .pos_y_o        (s1_y),
    .nonzero_o      (nz1)
  );

  // ---------------------------------------------------------------- results
  assign coord    = (pkt_q[7:0] == CoordPacket);
  assign all_lift = (pkt_q[58:57] == 2'b00);

  // a finger is reported when it lands/moves, or when a pressed one lifts
  assign rep0 = (!all_lift && nz0) || pressed_q[0];
  assign rep1 = (!all_lift && nz1) || pressed_q[1];

  always_comb begin
    r0.event_kind   = KindContact;
    r0.contact_slot = 1'b0;
    r0.touching     = !all_lift && nz0;
    r0.pos_x        = r0.touching ? s0_x : last0_x_q;
    r0.pos_y        = r0.touching ? s0_y : last0_y_q;
    r0.last_of_run  = 1'b0;

    r1.event_kind   = KindContact;
    r1.contact_slot = 1'b1;
    r1.touching     = !all_lift && nz1;
    r1.pos_x        = r1.touching ? s1_x : last1_x_q;
    r1.pos_y        = r1.touching ? s1_y : last1_y_q;
    r1.last_of_run  = 1'b0;

    sync_r              = '0;
    sync_r.event_kind   = KindFrameSync;
    sync_r.last_of_run  = 1'b1;
  end

  assign pressed_d = all_lift ? 2'b00 : {nz1, nz0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      last0_x_q <= '0;
      last0_y_q <= '0;
      last1_x_q <= '0;
      last1_y_q <= '0;
    end else if (load_w && coord) begin
      pressed_q <= pressed_d;
      if (!all_lift && nz0) begin
        last0_x_q <= s0_x;
        last0_y_q <= s0_y;
      end
      if (!all_lift && nz1) begin
        last1_x_q <= s1_x;
        last1_y_q <= s1_y;
      end
    end
  end

  // ---------------------------------------------------------------- result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_w) begin
      cnt_q <= coord ? 2'd1 + 2'(rep0) + 2'(rep1) : 2'd0;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      ent_q[0] <= rep0 ? r0 : (rep1 ? r1 : sync_r);
      ent_q[1] <= (rep0 && rep1) ? r1 : sync_r;
      ent_q[2] <= sync_r;
    end else if (out_fire) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {6'b0, ent_q[0].pos_y, ent_q[0].pos_x,
                          ent_q[0].touching, ent_q[0].contact_slot};
  assign m_axis_tlast  = ent_q[0].last_of_run;
  assign m_axis_tuser  = ent_q[0].event_kind;

  // ---------------------------------------------------------------- checks
  a_last_is_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("tlast beat is not a frame sync");

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> m_axis_tlast)
    else $error("final buffered beat lacks tlast");

  a_mask_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_w |=> $stable(pressed_q))
    else $error("contact mask changed without a packet");

  a_pkt_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !load_w |=> in_valid_q)
    else $error("buffered packet dropped");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-finger touch contact tracker. Packets go in
// on s_axis in random bursts. Contact reports and frame syncs coming out of
// m_axis are compared against a scoreboard that tracks the pressed mask and
// the last positions. Both display modes and both flip settings are covered.
// ----------------------------------------------------------------------------
module tb_top;
  import tpct_pkg::*;

  localparam logic [7:0] FingerStateMask = 8'h06;
  localparam int unsigned HoldCycles     = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic        cfg_wdata = 1'b0;

  // scoreboard copy of the tracker state
  logic        mode_q = 1'b0;
  logic        flip_q = 1'b0;
  logic [1:0]  pressed_q = '0;
  logic [11:0] last_x_q [2] = '{default: '0};
  logic [11:0] last_y_q [2] = '{default: '0};
  res_t        contact_q [$];

  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int          n_errors = 0;
  int          n_packets = 0;
  int          n_coord = 0;
  int          n_beats = 0;
  int          n_cfg = 0;

  always #10 clk = ~clk;

  touch_packet_contact_tracker_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------
  function automatic void scale_point(input logic [7:0] hi, input logic [7:0] xl,
                                      input logic [7:0] yl, output logic [11:0] sx,
                                      output logic [11:0] sy, output logic nz);
    int unsigned rx, ry, t;
    rx = {hi[7:4], xl};
    ry = {hi[3:0], yl};
    if (mode_q) begin
      t  = rx * 757 / 832;
      sx = 12'(ry * 1023 / 1280);
      sy = flip_q ? ((t > 757) ? 12'd0 : 12'(757 - t)) : 12'(t);
    end else begin
      t  = rx * 799 / 1088;
      sx = (t > 799) ? 12'd0 : 12'(799 - t);
      sy = 12'(ry * 599 / 768);
    end
    nz = (rx | ry) != 0;
  endfunction

  function automatic void push_contact(input logic kind, input logic slot,
                                       input logic touch, input logic [11:0] x,
                                       input logic [11:0] y, input logic last);
    res_t r;
    r.event_kind   = kind;
    r.contact_slot = slot;
    r.touching     = touch;
    r.pos_x        = x;
    r.pos_y        = y;
    r.last_of_run  = last;
    contact_q.push_back(r);
  endfunction

  function automatic void track_packet(input logic [63:0] pkt);
    logic [11:0] sx, sy;
    logic        nz;
    logic [7:0]  st;
    st = pkt[63:56];
    if (pkt[7:0] != CoordPacket) return;
    n_coord++;
    if ((st & FingerStateMask) == '0) begin
      for (int s = 0; s < 2; s++)
        if (pressed_q[s]) push_contact(KindContact, 1'(s), 1'b0, last_x_q[s], last_y_q[s], 1'b0);
      pressed_q = '0;
    end else begin
      for (int s = 0; s < 2; s++) begin
        scale_point(pkt[8 + 24*s +: 8], pkt[16 + 24*s +: 8], pkt[24 + 24*s +: 8],
                    sx, sy, nz);
        if (nz) begin
          push_contact(KindContact, 1'(s), 1'b1, sx, sy, 1'b0);
          last_x_q[s]  = sx;
          last_y_q[s]  = sy;
          pressed_q[s] = 1'b1;
        end else if (pressed_q[s]) begin
          // lifted finger is released where it was last seen
          push_contact(KindContact, 1'(s), 1'b0, last_x_q[s], last_y_q[s], 1'b0);
          pressed_q[s] = 1'b0;
        end
      end
    end
    push_contact(KindFrameSync, 1'b0, 1'b0, 12'd0, 12'd0, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Packet builders
  // --------------------------------------------------------------------------
  function automatic logic [63:0] mk_pkt(input logic [7:0] kind, input logic [7:0] h1,
                                         input logic [7:0] x1, input logic [7:0] y1,
                                         input logic [7:0] h2, input logic [7:0] x2,
                                         input logic [7:0] y2, input logic [7:0] st);
    return {st, y2, x2, h2, y1, x1, h1, kind};
  endfunction

  function automatic logic [63:0] rand_packet();
    logic [7:0] kind, st;
    logic [7:0] pt [6];
    int         sel;
    kind = ($urandom_range(0, 99) < 85) ? CoordPacket : 8'($urandom_range(0, 255));
    for (int f = 0; f < 2; f++) begin
      sel = $urandom_range(0, 9);
      for (int b = 0; b < 3; b++)
        pt[3*f + b] = (sel < 3) ? 8'h00 : (sel == 3) ? 8'hFF : 8'($urandom_range(0, 255));
    end
    st = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) st = st & ~FingerStateMask;
    return {st, pt[5], pt[4], pt[3], pt[2], pt[1], pt[0], kind};
  endfunction

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------
  task automatic send_packet(input logic [63:0] pkt);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom, $urandom};
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pkt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_packet(pkt);
    burst_left--;
    n_packets++;
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // registers change only with the pipe drained; ignored packets may still sit
  // in the input register, so the task waits on after the scoreboard queue empties
  task automatic write_reg(input logic idx, input logic val);
    idle_sender();
    while (contact_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CfgDisplayMode) mode_q = val;
    else flip_q = val;
    n_cfg++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t exp_r;
    res_t got;
    cycle_cnt++;
    if (m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      got.event_kind   = m_axis_tuser;
      got.contact_slot = m_axis_tdata[0];
      got.touching     = m_axis_tdata[1];
      got.pos_x        = m_axis_tdata[13:2];
      got.pos_y        = m_axis_tdata[25:14];
      got.last_of_run  = m_axis_tlast;
      if (contact_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected beat %p", got);
      end else begin
        exp_r = contact_q.pop_front();
        if (got.event_kind !== exp_r.event_kind || got.contact_slot !== exp_r.contact_slot ||
            got.touching !== exp_r.touching || got.pos_x !== exp_r.pos_x ||
            got.pos_y !== exp_r.pos_y || got.last_of_run !== exp_r.last_of_run) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: beat mismatch exp %p got %p", exp_r, got);
        end
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      // stall profile is picked by cycle_cnt[8:6]
      case (cycle_cnt[8:6])
        3'd0, 3'd5: m_axis_tready <= 1'b1;
        3'd1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
        3'd2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        3'd3:       m_axis_tready <= (cycle_cnt % 3 != 0);
        default:    m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_packet(mk_pkt(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_packet(mk_pkt(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_packet(mk_pkt(8'h5B, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'h06));
    // lift-all and zero points with nothing pressed: frame sync only
    send_packet(mk_pkt(CoordPacket, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h00));
    send_packet(mk_pkt(CoordPacket, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02));
    // full-scale X drives the mode 0 subtraction below zero
    send_packet(mk_pkt(CoordPacket, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02));
    send_packet(mk_pkt(CoordPacket, 8'h0F, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h04));
    send_packet(mk_pkt(CoordPacket, 8'h37, 8'hA5, 8'h5A, 8'hC3, 8'h0F, 8'hF0, 8'h06));
    send_packet(mk_pkt(CoordPacket, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'hF9));
    send_packet(mk_pkt(CoordPacket, 8'h44, 8'h10, 8'h20, 8'h88, 8'h30, 8'h40, 8'hFF));
    send_packet(mk_pkt(CoordPacket, 8'h00, 8'h00, 8'h00, 8'h21, 8'h43, 8'h65, 8'h02));
    send_packet(mk_pkt(CoordPacket, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04));
    send_packet(mk_pkt(CoordPacket, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06));
    send_packet(mk_pkt(CoordPacket, 8'h99, 8'h99, 8'h99, 8'h66, 8'h66, 8'h66, 8'h01));
  endtask

  task automatic test_config_sweep();
    logic [1:0] sweep [4] = '{2'b10, 2'b11, 2'b01, 2'b00};
    for (int i = 0; i < 4; i++) begin
      write_reg(CfgDisplayMode, sweep[i][1]);
      write_reg(CfgFlipVertical, sweep[i][0]);
      send_packet(mk_pkt(CoordPacket, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02));
      send_packet(mk_pkt(CoordPacket, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04));
      send_packet(mk_pkt(CoordPacket, 8'hF0, 8'hFF, 8'h00, 8'h0F, 8'h00, 8'hFF, 8'h06));
      send_packet(mk_pkt(CoordPacket, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      repeat (6) send_packet(rand_packet());
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 60; i++) begin
      if (i % 30 == 29) begin
        write_reg(CfgDisplayMode, 1'($urandom_range(0, 1)));
        write_reg(CfgFlipVertical, 1'($urandom_range(0, 1)));
      end
      send_packet(rand_packet());
    end
  endtask

  // receiver holds off while packets keep coming, so the input side backs up
  task automatic test_backpressure();
    write_reg(CfgDisplayMode, 1'b1);
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    for (int i = 0; i < 16; i++)
      send_packet(mk_pkt(CoordPacket, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h06));
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    idle_sender();
    while (contact_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d packets (%0d coordinate) and %0d checked beats,",
             n_packets, n_coord, n_beats);
    $display("across %0d register writes in both display modes with and without flip.",
             n_cfg);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d beats outstanding", contact_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tpct_pkg.sv
hw/rtl/tpct_scaler.sv
hw/rtl/touch_packet_contact_tracker_unit.sv
tb/tb_top.sv
